// ===== design/irt_pkg.sv =====
// ----------------------------------------------------------------------------
// irt_pkg: shared types and codes of the IPv4 route table
// Request/response payloads, route entry layout, opcodes and error codes.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int ENTRIES_DEF = 8;
    localparam int IFACES      = 8;
    localparam int IFACE_W     = $clog2(IFACES);

    // opcodes
    localparam logic [1:0] OP_ADD       = 2'd0;
    localparam logic [1:0] OP_DEL_DEST  = 2'd1;
    localparam logic [1:0] OP_DEL_IFACE = 2'd2;
    localparam logic [1:0] OP_LOOKUP    = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_FULL        = 2'd1;
    localparam logic [1:0] ERR_DEFAULT_DEL = 2'd2;
    localparam logic [1:0] ERR_NOT_FOUND   = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        dest_addr;
        logic [31:0]        gateway_addr;
        logic [31:0]        net_mask;
        logic [31:0]        src_addr;
        logic [IFACE_W-1:0] iface_id;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [1:0]         err_code;
        logic [IFACE_W-1:0] hit_iface;
        logic [31:0]        hit_source;
        logic [31:0]        hit_gateway;
    } t_rsp;

    // one stored route, rank kept apart (its width follows the depth)
    typedef struct packed {
        logic [31:0]        dest;
        logic [31:0]        gateway;
        logic [31:0]        mask;
        logic [31:0]        source;
        logic [IFACE_W-1:0] iface;
    } t_route;

    // table write controls
    typedef struct packed {
        logic route_we;
        logic rank_we;
        logic set_vld;
        logic clr_vld;
    } t_wr_ctl;

    // compare unit flags, all qualified by the entry valid bit
    typedef struct packed {
        logic dest_eq;
        logic iface_eq;
        logic route_hit;
        logic dflt_hit;
        logic rank_gt;
        logic rank_lt;
    } t_cmp;

endpackage

// ===== design/irt_store.sv =====
// ----------------------------------------------------------------------------
// irt_store: route table storage
// Route and rank memories with one read and one write port, registered read
// data; per-entry valid bits in flops cleared by reset.
// ----------------------------------------------------------------------------
module irt_store #(
    parameter  int ENTRIES = irt_pkg::ENTRIES_DEF,
    localparam int AW      = $clog2(ENTRIES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  irt_pkg::t_wr_ctl i_wr_ctl,
    input  logic [AW-1:0]    i_wr_addr,
    input  irt_pkg::t_route  i_wr_route,
    input  logic [AW-1:0]    i_wr_rank,
    output irt_pkg::t_route  o_rd_route,
    output logic [AW-1:0]    o_rd_rank,
    output logic             o_rd_valid
);

    irt_pkg::t_route r_route_mem [ENTRIES];
    logic [AW-1:0]   r_rank_mem  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    irt_pkg::t_route r_rd_route;
    logic [AW-1:0]   r_rd_rank;
    logic            r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.route_we) begin
            r_route_mem[i_wr_addr] <= i_wr_route;
        end
        if (i_wr_ctl.rank_we) begin
            r_rank_mem[i_wr_addr] <= i_wr_rank;
        end
        if (i_rd_en) begin
            r_rd_route <= r_route_mem[i_rd_addr];
            r_rd_rank  <= r_rank_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_ctl.set_vld) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_wr_ctl.clr_vld) begin
                r_valid[i_wr_addr] <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_route = r_rd_route;
    assign o_rd_rank  = r_rd_rank;
    assign o_rd_valid = r_rd_valid;

endmodule

// ===== design/irt_cmp.sv =====
// ----------------------------------------------------------------------------
// irt_cmp: shared compare unit
// Matches one stored entry against the request and a reference rank, and
// produces the stepped rank used to renumber entries.
// ----------------------------------------------------------------------------
module irt_cmp #(
    parameter  int ENTRIES = irt_pkg::ENTRIES_DEF,
    localparam int AW      = $clog2(ENTRIES)
) (
    input  irt_pkg::t_req   i_req,
    input  irt_pkg::t_route i_route,
    input  logic [AW-1:0]   i_rank,
    input  logic            i_valid,
    input  logic [AW-1:0]   i_ref_rank,
    input  logic            i_inc,
    output irt_pkg::t_cmp   o_flags,
    output logic [AW-1:0]   o_rank_next
);

    logic net_eq;

    // network part of the address against the stored network, under its mask
    assign net_eq = ((i_req.dest_addr & i_route.mask) == (i_route.dest & i_route.mask));

    always_comb begin
        o_flags.dest_eq   = i_valid && (i_route.dest == i_req.dest_addr);
        o_flags.iface_eq  = i_valid && (i_route.iface == i_req.iface_id);
        o_flags.dflt_hit  = i_valid && (i_route.dest == 32'd0);
        o_flags.route_hit = i_valid && (i_route.dest != 32'd0) && net_eq;
        o_flags.rank_gt   = i_valid && (i_rank > i_ref_rank);
        o_flags.rank_lt   = i_valid && (i_rank < i_ref_rank);
    end

    assign o_rank_next = i_inc ? (i_rank + AW'(1)) : (i_rank - AW'(1));

endmodule

// ===== design/ipv4_route_table_top.sv =====
// Sequencing: lookup and delete-miss answer after a scan of the table; an update in place
//   adds the write; insert adds a renumber walk and the write, delete by dest a renumber
//   walk; delete by interface adds one renumber walk per removed route. Throughput: one
//   request at a time, set by the walk.
// Responses are a one-cycle strobe; the receiver cannot stall them.
// Reset: synchronous, active low; clears all valid bits at once, no clearing pass.
// ----------------------------------------------------------------------------
// ipv4_route_table_top: fixed IPv4 route table with first-match lookup
// A small sequencer walks the table one entry per cycle through a single
// shared compare unit. Ranks order the routes by insertion, rank 0 newest.
// ----------------------------------------------------------------------------
module ipv4_route_table_top #(
    parameter int ENTRIES = irt_pkg::ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  irt_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_strobe,
    output irt_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
    localparam logic [AW-1:0] IDX_LAST = AW'(ENTRIES - 1);

    // IDLE  : wait for a request
    // SCAN  : walk the table, gather matches, free slot, best route
    // ADJ   : renumber ranks (insert: all up; drop: close the gap)
    // WRITE : store the route of an add
    // FIN   : build the response
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_ADJ   = 5'b00100,
        S_WRITE = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    // control registers
    t_state        r_state,    n_state;
    logic [CW-1:0] r_cnt,      n_cnt;       // next entry to read
    logic          r_pend,     n_pend;      // read data of r_pidx is on hand
    logic          r_strobe,   n_strobe;
    logic          r_hit,      n_hit;       // dest match found / drop done
    logic          r_free_fnd, n_free_fnd;
    logic          r_best_fnd, n_best_fnd;
    logic          r_dflt_fnd, n_dflt_fnd;

    // payload registers
    irt_pkg::t_req   r_req,      n_req;
    logic [AW-1:0]   r_pidx,     n_pidx;
    logic [AW-1:0]   r_hit_idx,  n_hit_idx;
    logic [AW-1:0]   r_free_idx, n_free_idx;
    logic [AW-1:0]   r_rank,     n_rank;    // dropped rank, or best rank on lookup
    logic [CW-1:0]   r_resume,   n_resume;  // where a delete-by-interface scan goes on
    irt_pkg::t_route r_best,     n_best;
    irt_pkg::t_route r_dflt,     n_dflt;
    irt_pkg::t_rsp   r_rsp,      n_rsp;

    // table and compare unit hookup
    logic             rd_en;
    irt_pkg::t_wr_ctl wr_ctl;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    wr_rank;
    irt_pkg::t_route  wr_route;
    irt_pkg::t_route  rd_route;
    logic [AW-1:0]    rd_rank;
    logic             rd_valid;
    irt_pkg::t_cmp    flags;
    logic [AW-1:0]    rank_next;

    logic issue;
    logic pend_last;
    logic drop;

    irt_store #(.ENTRIES(ENTRIES)) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_cnt[AW-1:0]),
        .i_wr_ctl   (wr_ctl),
        .i_wr_addr  (wr_addr),
        .i_wr_route (wr_route),
        .i_wr_rank  (wr_rank),
        .o_rd_route (rd_route),
        .o_rd_rank  (rd_rank),
        .o_rd_valid (rd_valid)
    );

    irt_cmp #(.ENTRIES(ENTRIES)) u_cmp (
        .i_req       (r_req),
        .i_route     (rd_route),
        .i_rank      (rd_rank),
        .i_valid     (rd_valid),
        .i_ref_rank  (r_rank),
        .i_inc       (r_req.op == irt_pkg::OP_ADD),
        .o_flags     (flags),
        .o_rank_next (rank_next)
    );

    // route written on add; dest is rewritten unchanged on an update
    always_comb begin
        wr_route.dest    = r_req.dest_addr;
        wr_route.gateway = r_req.gateway_addr;
        wr_route.mask    = r_req.net_mask;
        wr_route.source  = r_req.src_addr;
        wr_route.iface   = r_req.iface_id;
    end

    assign issue     = (r_cnt < CNT_END);
    assign pend_last = r_pend && (r_pidx == IDX_LAST);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pend     = 1'b0;
        n_strobe   = 1'b0;
        n_hit      = r_hit;
        n_free_fnd = r_free_fnd;
        n_best_fnd = r_best_fnd;
        n_dflt_fnd = r_dflt_fnd;
        n_req      = r_req;
        n_pidx     = r_pidx;
        n_hit_idx  = r_hit_idx;
        n_free_idx = r_free_idx;
        n_rank     = r_rank;
        n_resume   = r_resume;
        n_best     = r_best;
        n_dflt     = r_dflt;
        n_rsp      = r_rsp;
        rd_en      = 1'b0;
        wr_ctl     = '0;
        wr_addr    = r_pidx;
        wr_rank    = rank_next;
        drop       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req      = i_req;
                    n_hit      = 1'b0;
                    n_free_fnd = 1'b0;
                    n_best_fnd = 1'b0;
                    n_dflt_fnd = 1'b0;
                    n_cnt      = '0;
                    // the default route cannot be deleted: answer at once
                    if ((i_req.op == irt_pkg::OP_DEL_DEST) && (i_req.dest_addr == 32'd0)) begin
                        n_strobe       = 1'b1;
                        n_rsp          = '0;
                        n_rsp.err_code = irt_pkg::ERR_DEFAULT_DEL;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                rd_en  = issue;
                n_pend = issue;
                n_pidx = r_cnt[AW-1:0];
                if (issue) begin
                    n_cnt = r_cnt + CW'(1);
                end
                if (r_pend) begin
                    case (r_req.op)
                        irt_pkg::OP_ADD: begin
                            if (flags.dest_eq) begin
                                n_hit     = 1'b1;
                                n_hit_idx = r_pidx;
                            end
                            // lowest free slot
                            if (!rd_valid && !r_free_fnd) begin
                                n_free_fnd = 1'b1;
                                n_free_idx = r_pidx;
                            end
                        end
                        irt_pkg::OP_DEL_DEST: begin
                            drop = flags.dest_eq;
                        end
                        irt_pkg::OP_DEL_IFACE: begin
                            drop = flags.iface_eq;
                        end
                        irt_pkg::OP_LOOKUP: begin
                            // newest matching non-default route wins
                            if (flags.route_hit && (!r_best_fnd || flags.rank_lt)) begin
                                n_best_fnd = 1'b1;
                                n_rank     = rd_rank;
                                n_best     = rd_route;
                            end
                            if (flags.dflt_hit) begin
                                n_dflt_fnd = 1'b1;
                                n_dflt     = rd_route;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (drop) begin
                    // remove now, then close the rank gap it leaves
                    wr_ctl.clr_vld = 1'b1;
                    n_hit          = 1'b1;
                    n_rank         = rd_rank;
                    n_resume       = CW'(r_pidx) + CW'(1);
                    n_cnt          = '0;
                    n_pend         = 1'b0;
                    n_state        = S_ADJ;
                end else if (pend_last) begin
                    n_pend = 1'b0;
                    n_cnt  = '0;
                    if (r_req.op == irt_pkg::OP_ADD) begin
                        if (n_hit) begin
                            n_state = S_WRITE;
                        end else if (n_free_fnd) begin
                            n_state = S_ADJ;
                        end else begin
                            n_state = S_FIN;
                        end
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end

            S_ADJ: begin
                rd_en  = issue;
                n_pend = issue;
                n_pidx = r_cnt[AW-1:0];
                if (issue) begin
                    n_cnt = r_cnt + CW'(1);
                end
                if (r_pend) begin
                    if (r_req.op == irt_pkg::OP_ADD) begin
                        wr_ctl.rank_we = rd_valid;
                    end else begin
                        wr_ctl.rank_we = flags.rank_gt;
                    end
                end
                if (pend_last) begin
                    n_pend = 1'b0;
                    if (r_req.op == irt_pkg::OP_ADD) begin
                        n_state = S_WRITE;
                    end else if ((r_req.op == irt_pkg::OP_DEL_IFACE) && (r_resume < CNT_END)) begin
                        n_state = S_SCAN;
                        n_cnt   = r_resume;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end

            S_WRITE: begin
                // update keeps slot and rank; insert takes the free slot as rank 0
                wr_addr         = r_hit ? r_hit_idx : r_free_idx;
                wr_rank         = '0;
                wr_ctl.route_we = 1'b1;
                wr_ctl.rank_we  = !r_hit;
                wr_ctl.set_vld  = !r_hit;
                n_state         = S_FIN;
            end

            S_FIN: begin
                n_strobe = 1'b1;
                n_rsp    = '0;
                n_state  = S_IDLE;
                case (r_req.op)
                    irt_pkg::OP_ADD: begin
                        if (r_hit || r_free_fnd) begin
                            n_rsp.ok = 1'b1;
                        end else begin
                            n_rsp.err_code = irt_pkg::ERR_FULL;
                        end
                    end
                    irt_pkg::OP_DEL_DEST: begin
                        if (r_hit) begin
                            n_rsp.ok = 1'b1;
                        end else begin
                            n_rsp.err_code = irt_pkg::ERR_NOT_FOUND;
                        end
                    end
                    irt_pkg::OP_DEL_IFACE: begin
                        n_rsp.ok = 1'b1;
                    end
                    irt_pkg::OP_LOOKUP: begin
                        if (r_best_fnd) begin
                            n_rsp.ok          = 1'b1;
                            n_rsp.hit_iface   = r_best.iface;
                            n_rsp.hit_source  = r_best.source;
                            n_rsp.hit_gateway = r_best.gateway;
                        end else if (r_dflt_fnd) begin
                            n_rsp.ok          = 1'b1;
                            n_rsp.hit_iface   = r_dflt.iface;
                            n_rsp.hit_source  = r_dflt.source;
                            n_rsp.hit_gateway = r_dflt.gateway;
                        end else begin
                            n_rsp.err_code = irt_pkg::ERR_NOT_FOUND;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_pend     <= 1'b0;
            r_strobe   <= 1'b0;
            r_hit      <= 1'b0;
            r_free_fnd <= 1'b0;
            r_best_fnd <= 1'b0;
            r_dflt_fnd <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_pend     <= n_pend;
            r_strobe   <= n_strobe;
            r_hit      <= n_hit;
            r_free_fnd <= n_free_fnd;
            r_best_fnd <= n_best_fnd;
            r_dflt_fnd <= n_dflt_fnd;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_pidx     <= n_pidx;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_rank     <= n_rank;
        r_resume   <= n_resume;
        r_best     <= n_best;
        r_dflt     <= n_dflt;
        r_rsp      <= n_rsp;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

`ifndef SYNTHESIS
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start || o_busy))
        else $error("response without a request in flight");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_END)
        else $error("walk counter past table end");

    a_pend_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((r_state == S_SCAN) || (r_state == S_ADJ)))
        else $error("read data pending outside a table walk");

    a_ok_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.ok) |-> (o_rsp.err_code == irt_pkg::ERR_NONE))
        else $error("error code set on a good response");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_rsp.ok) |->
            ((o_rsp.hit_gateway == 32'd0) && (o_rsp.hit_source == 32'd0)))
        else $error("route data on a failed response");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the IPv4 route table
// Drives a short table of directed requests, then about a thousand random
// ones built around a small pool of networks so that updates, deletes, full
// table and default-route fallback all happen often. Every response is
// compared field by field against a typed-in value or a behavioral copy of the table.
// ----------------------------------------------------------------------------
module tb;

    localparam int ENTRIES    = irt_pkg::ENTRIES_DEF;
    localparam int RANK_W     = $clog2(ENTRIES);
    localparam int IFACE_W    = irt_pkg::IFACE_W;
    localparam int RAND_ITEMS = 1000;
    localparam int CALM_ITEMS = 150;                    // tail with no sender gaps
    localparam int POOL       = 12;                     // more networks than slots
    localparam int DRAIN      = 2 * (ENTRIES + 2) ** 2; // worst delete-by-iface walk
    localparam int WATCHDOG   = 20 * (ENTRIES + 2) ** 2;

    // typed-in responses for directed rows
    localparam irt_pkg::t_rsp RSP_DONE     =
        '{1'b1, irt_pkg::ERR_NONE, 3'd0, 32'd0, 32'd0};
    localparam irt_pkg::t_rsp RSP_FULL     =
        '{1'b0, irt_pkg::ERR_FULL, 3'd0, 32'd0, 32'd0};
    localparam irt_pkg::t_rsp RSP_DFLT_DEL =
        '{1'b0, irt_pkg::ERR_DEFAULT_DEL, 3'd0, 32'd0, 32'd0};
    localparam irt_pkg::t_rsp RSP_MISS     =
        '{1'b0, irt_pkg::ERR_NOT_FOUND, 3'd0, 32'd0, 32'd0};
    localparam irt_pkg::t_rsp RSP_DFLT_ALL =
        '{1'b1, irt_pkg::ERR_NONE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

    // one directed request; typed=0 means the response comes from the table copy
    typedef struct {
        irt_pkg::t_req req;
        bit            typed;
        irt_pkg::t_rsp rsp;
    } t_dir_row;

    localparam int DIR_ROWS = 26;

    // Directed sequence. Empty-table corner cases first, then a default
    // route with all-ones payload, two overlapping 192.168 routes (newest
    // wins, update keeps the old rank), fill to the last slot, a refused
    // insert on a full table, an update that still works while full, and
    // deletes that peel the table back down to a lookup miss.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{irt_pkg::OP_LOOKUP,    32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b1, RSP_MISS},
        '{'{irt_pkg::OP_DEL_DEST,  32'h0000_0000, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b1,
          RSP_DFLT_DEL},
        '{'{irt_pkg::OP_DEL_DEST,  32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b1, RSP_MISS},
        '{'{irt_pkg::OP_DEL_IFACE, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 3'd7}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
            3'd7}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_LOOKUP,    32'h1234_5678, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b1,
          RSP_DFLT_ALL},
        '{'{irt_pkg::OP_ADD, 32'hC0A8_0100, 32'hC0A8_0101, 32'hFFFF_FF00, 32'hC0A8_0102,
            3'd1}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_ADD, 32'hC0A8_0000, 32'hC0A8_0001, 32'hFFFF_0000, 32'hC0A8_0002,
            3'd2}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_LOOKUP,    32'hC0A8_0105, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b0, '0},
        '{'{irt_pkg::OP_ADD, 32'hC0A8_0100, 32'h0A0A_0A0A, 32'hFFFF_FF00, 32'h0B0B_0B0B,
            3'd3}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_LOOKUP,    32'hC0A8_01FF, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b0, '0},
        '{'{irt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
            3'd0}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_ADD, 32'h0A00_0000, 32'h0A00_0001, 32'hFF00_0000, 32'h0A00_00FE,
            3'd4}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_ADD, 32'h0A01_0000, 32'h0A01_0001, 32'hFFFF_0000, 32'h0A01_00FE,
            3'd5}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_ADD, 32'hAC10_0000, 32'hAC10_0001, 32'hFFF0_0000, 32'hAC10_00FE,
            3'd6}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_ADD, 32'h0000_0001, 32'h0101_0101, 32'hFFFF_FFFF, 32'h0202_0202,
            3'd1}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_ADD, 32'h0A02_0000, 32'h0A02_0001, 32'hFFFF_0000, 32'h0A02_00FE,
            3'd2}, 1'b1, RSP_FULL},
        '{'{irt_pkg::OP_ADD, 32'h0A00_0000, 32'h5A5A_5A5A, 32'hFF00_0000, 32'hA5A5_A5A5,
            3'd4}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_LOOKUP,    32'h0A01_0203, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b0, '0},
        '{'{irt_pkg::OP_DEL_DEST,  32'h0A01_0000, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_LOOKUP,    32'h0A01_0203, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b0, '0},
        '{'{irt_pkg::OP_DEL_IFACE, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 3'd1}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_LOOKUP,    32'h0000_0001, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b0, '0},
        '{'{irt_pkg::OP_DEL_IFACE, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 3'd7}, 1'b1, RSP_DONE},
        '{'{irt_pkg::OP_LOOKUP,    32'h0000_0001, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b0, '0},
        '{'{irt_pkg::OP_LOOKUP,    32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 3'd0}, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // DUT hookup; all inputs known from time zero
    // ------------------------------------------------------------------------
    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_start = 1'b0;
    irt_pkg::t_req i_req   = '0;
    logic          o_busy;
    logic          o_strobe;
    irt_pkg::t_rsp o_rsp;

    // side band for the scoreboard: typed response of the request on i_req
    bit            row_typed = 1'b0;
    irt_pkg::t_rsp row_rsp   = '0;

    ipv4_route_table_top #(.ENTRIES(ENTRIES)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Behavioral copy of the route table
    // Only valid slots are ever read, so the stored fields need no reset.
    // ------------------------------------------------------------------------
    logic              route_vld  [ENTRIES];
    irt_pkg::t_route   route_tab  [ENTRIES];
    logic [RANK_W-1:0] route_rank [ENTRIES];  // 0 = most recently inserted

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            route_vld[i]  = 1'b0;
            route_tab[i]  = '0;
            route_rank[i] = '0;
        end
    end

    function automatic int find_route(input logic [31:0] dest);
        int slot;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && route_vld[i] && route_tab[i].dest == dest)
                slot = i;
        return slot;
    endfunction

    // free a slot and close the rank gap it leaves
    function automatic void drop_route(input int slot);
        route_vld[slot] = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (route_vld[i] && route_rank[i] > route_rank[slot])
                route_rank[i] = route_rank[i] - 1'b1;
    endfunction

    // applies one request to the table copy and returns its response
    function automatic irt_pkg::t_rsp apply_route_request(input irt_pkg::t_req req);
        irt_pkg::t_rsp rsp;
        int            slot;
        int            best;
        int            dflt;
        rsp  = '0;
        best = -1;
        dflt = -1;
        case (req.op)
            irt_pkg::OP_ADD: begin
                slot = find_route(req.dest_addr);
                if (slot < 0) begin
                    // new route goes in the lowest free slot, as the newest
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot < 0 && !route_vld[i])
                            slot = i;
                    if (slot >= 0) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (route_vld[i])
                                route_rank[i] = route_rank[i] + 1'b1;
                        route_vld[slot]      = 1'b1;
                        route_tab[slot].dest = req.dest_addr;
                        route_rank[slot]     = '0;
                    end
                end
                if (slot >= 0) begin
                    route_tab[slot].gateway = req.gateway_addr;
                    route_tab[slot].mask    = req.net_mask;
                    route_tab[slot].source  = req.src_addr;
                    route_tab[slot].iface   = req.iface_id;
                    rsp.ok = 1'b1;
                end else begin
                    rsp.err_code = irt_pkg::ERR_FULL;
                end
            end
            irt_pkg::OP_DEL_DEST: begin
                if (req.dest_addr == 32'd0) begin
                    rsp.err_code = irt_pkg::ERR_DEFAULT_DEL;
                end else begin
                    slot = find_route(req.dest_addr);
                    if (slot >= 0) begin
                        drop_route(slot);
                        rsp.ok = 1'b1;
                    end else begin
                        rsp.err_code = irt_pkg::ERR_NOT_FOUND;
                    end
                end
            end
            irt_pkg::OP_DEL_IFACE: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (route_vld[i] && route_tab[i].iface == req.iface_id)
                        drop_route(i);
                rsp.ok = 1'b1;
            end
            irt_pkg::OP_LOOKUP: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (route_vld[i]) begin
                        if (route_tab[i].dest == 32'd0) begin
                            dflt = i;
                        end else if ((req.dest_addr & route_tab[i].mask) ==
                                     (route_tab[i].dest & route_tab[i].mask)) begin
                            if (best < 0 || route_rank[i] < route_rank[best])
                                best = i;
                        end
                    end
                end
                if (best < 0)
                    best = dflt;
                if (best >= 0) begin
                    rsp.ok          = 1'b1;
                    rsp.hit_iface   = route_tab[best].iface;
                    rsp.hit_source  = route_tab[best].source;
                    rsp.hit_gateway = route_tab[best].gateway;
                end else begin
                    rsp.err_code = irt_pkg::ERR_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard
    // One process samples both handshakes at the edge, so the order of the
    // response pop and the request push within a time step is fixed here.
    // ------------------------------------------------------------------------
    irt_pkg::t_rsp pending_rsps [$];
    int            mismatch_cnt = 0;
    int            quiet_cycles = 0;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : score
        irt_pkg::t_rsp want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_rsps.size() == 0) begin
                    $display("%0t: response with none expected, expected none, got %h",
                             $time, o_rsp);
                    mismatch_cnt++;
                end else begin
                    want = pending_rsps.pop_front();
                    check_field("ok",          32'(want.ok),        32'(o_rsp.ok));
                    check_field("err_code",    32'(want.err_code),  32'(o_rsp.err_code));
                    check_field("hit_iface",   32'(want.hit_iface), 32'(o_rsp.hit_iface));
                    check_field("hit_source",  want.hit_source,     o_rsp.hit_source);
                    check_field("hit_gateway", want.hit_gateway,    o_rsp.hit_gateway);
                end
            end
            // request taken at this edge: predict now, in acceptance order
            if (i_start && !o_busy) begin
                want = apply_route_request(i_req);
                pending_rsps.push_back(row_typed ? row_rsp : want);
            end
            // watchdog: cycles with neither a request nor a response moving
            if ((i_start && !o_busy) || o_strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    logic [31:0] net_pool [POOL];
    int          net_len  [POOL];

    function automatic logic [31:0] prefix_mask(input int len);
        return (len == 0) ? 32'h0 : (~32'h0 << (32 - len));
    endfunction

    // Mostly well-formed traffic on the pool networks (so adds collide,
    // deletes hit and the table keeps filling up), with some noise.
    // Unused fields carry random bits on every op.
    function automatic irt_pkg::t_req random_request();
        irt_pkg::t_req req;
        int            sel;
        int            k;
        int            pick;
        sel  = $urandom_range(0, 99);
        k    = $urandom_range(0, POOL - 1);
        pick = $urandom_range(0, 99);
        req.dest_addr    = $urandom;
        req.gateway_addr = $urandom;
        req.net_mask     = $urandom;
        req.src_addr     = $urandom;
        req.iface_id     = IFACE_W'($urandom_range(0, irt_pkg::IFACES - 1));
        if (sel < 35) begin
            req.op = irt_pkg::OP_ADD;
            if (pick < 85)
                req.dest_addr = net_pool[k];
            // mask: the network's own prefix, another prefix, or raw bits
            if (pick < 60)
                req.net_mask = prefix_mask(net_len[k]);
            else if (pick < 90)
                req.net_mask = prefix_mask($urandom_range(0, 32));
        end else if (sel < 50) begin
            req.op = irt_pkg::OP_DEL_DEST;
            if (pick < 80)
                req.dest_addr = net_pool[k];
        end else if (sel < 58) begin
            req.op = irt_pkg::OP_DEL_IFACE;
        end else begin
            req.op = irt_pkg::OP_LOOKUP;
            // host inside a pool network, else a random address
            if (pick < 75)
                req.dest_addr = net_pool[k] | ($urandom & ~prefix_mask(net_len[k]));
        end
        return req;
    endfunction

    // present a request after an optional gap and hold it until taken
    task automatic send_request(input irt_pkg::t_req req, input bit typed,
                                input irt_pkg::t_rsp rsp, input int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_req     <= req;
        row_typed <= typed;
        row_rsp   <= rsp;
        do @(posedge i_clk); while (o_busy);
    endtask

    // stop sending until every outstanding response is back
    task automatic wait_drained();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_rsps.size() != 0);
    endtask

    // gap before a request: random bursts, none in the calm tail
    function automatic int pick_gap(input int idx, input int total);
        if (idx < total - CALM_ITEMS && $urandom_range(0, 99) < 20)
            return $urandom_range(1, 17);
        return 0;
    endfunction

    initial begin
        // network pool; slot 0 is the default route
        net_pool[0] = 32'd0;
        net_len[0]  = 0;
        for (int k = 1; k < POOL; k++) begin
            net_len[k]  = $urandom_range(8, 32);
            net_pool[k] = $urandom & prefix_mask(net_len[k]);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, gaps here too so early phases see idle cycles
        for (int n = 0; n < DIR_ROWS; n++)
            send_request(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].rsp,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0);
        wait_drained();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2)
                wait_drained();
            send_request(random_request(), 1'b0, '0, pick_gap(n, RAND_ITEMS));
        end

        // drain, then give a slow interface delete time to show a stray strobe
        wait_drained();
        repeat (DRAIN) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/irt_pkg.sv
design/irt_store.sv
design/irt_cmp.sv
design/ipv4_route_table_top.sv
tb/tb.sv
